/* design/multiquadric_kernel_operator_core_macros.svh */
// Assertion macros shared by the multiquadric kernel operator design.
`ifndef MULTIQUADRIC_KERNEL_OPERATOR_CORE_MACROS_SVH
`define MULTIQUADRIC_KERNEL_OPERATOR_CORE_MACROS_SVH
// The consequent must hold in the same cycle as the antecedent.
`define MQK_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold a fixed number of cycles after the antecedent.
`define MQK_ASSERT_AFTER(name, ante, dly, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);
`endif

/* design/mqk_pkg.sv */
// Types and constants of the multiquadric kernel operator.
package mqk_pkg;

  localparam int OUT_W = 48;

  localparam logic [2:0] OP_VALUE   = 3'd0;
  localparam logic [2:0] OP_LAPLACE = 3'd1;
  localparam logic [2:0] OP_DIV     = 3'd2;
  localparam logic [2:0] OP_DX      = 3'd3;
  localparam logic [2:0] OP_DY      = 3'd4;
  localparam logic [2:0] OP_DZ      = 3'd5;
  localparam logic [2:0] OP_NEUMANN = 3'd6;
  localparam logic [2:0] OP_UNDEF   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OP   = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN = 2'd2;

  localparam logic REG_SHAPE = 1'b0;
  localparam logic REG_DIM   = 1'b1;

  localparam logic [31:0] SHAPE_RESET = 32'd65536;
  localparam logic [1:0]  DIM_RESET   = 2'd3;

  localparam logic [OUT_W-1:0] OUT_POS_LIM = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_NEG_LIM = 48'h8000_0000_0000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] kernel_value;
    logic [1:0]              status;
  } out_item_t;

endpackage

/* design/multiquadric_kernel_operator_core.sv */
// Top level of the multiquadric kernel operator: a fully pipelined datapath.
// The block takes one item in every cycle; busy is high only during reset. Each
// item runs through four arithmetic stages, a square root that resolves one root
// bit per stage (33+FRAC_BITS stages), a divider for the Laplacian quotient that
// resolves one bit per stage (2*FRAC_BITS+2 stages) and a final divider with one
// bit per stage (48 stages); out_valid then pulses for the item from the output
// register behind the final divider. The result is shown for exactly one cycle
// and the receiver cannot stall it.
`include "multiquadric_kernel_operator_core_macros.svh"
module multiquadric_kernel_operator_core import mqk_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW   = 33;
  localparam int QW   = 66;
  localparam int NW   = 68;
  localparam int SW   = 33 + FRAC_BITS;
  localparam int D1Q  = 2 * FRAC_BITS + 2;
  localparam int D1RW = QW + 1;
  localparam int D2DW = 67 + FRAC_BITS;
  localparam int D2RW = SW + 1;
  localparam int LAT  = 3 * FRAC_BITS + 90;

  typedef struct packed {
    logic [2:0]    op;
    logic [1:0]    status;
    logic          neg;
    logic          ovf;
    logic [QW-1:0] q;
    logic [NW-1:0] numer;
    logic [SW-1:0] s2;
  } ctx_t;

  logic [31:0] shape_r;
  logic [1:0]  dim_r;
  logic        accept;

  assign busy   = !rst_n;
  assign accept = start && !busy;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHAPE_RESET;
      dim_r   <= DIM_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DIM) begin
        dim_r <= pwdata[1:0];
      end else begin
        shape_r <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_DIM) begin
      prdata = {30'd0, dim_r};
    end else begin
      prdata = shape_r;
    end
  end

  // Stage 1: coordinate differences.
  logic                 p1_v_r;
  logic [2:0]           p1_op_r;
  logic signed [RW-1:0] p1_d_r [3];
  logic signed [31:0]   p1_n_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p1_op_r   <= in_item.opcode;
    p1_d_r[0] <= {in_item.first_x[31], in_item.first_x} - {in_item.second_x[31], in_item.second_x};
    p1_d_r[1] <= {in_item.first_y[31], in_item.first_y} - {in_item.second_y[31], in_item.second_y};
    p1_d_r[2] <= {in_item.first_z[31], in_item.first_z} - {in_item.second_z[31], in_item.second_z};
    p1_n_r[0] <= in_item.normal_x;
    p1_n_r[1] <= in_item.normal_y;
    p1_n_r[2] <= in_item.normal_z;
  end

  // Stage 2: products.
  logic                 p2_v_r;
  logic [2:0]           p2_op_r;
  logic [63:0]          p2_sq_r [3];
  logic [63:0]          p2_c2_r;
  logic signed [64:0]   p2_np_r [3];
  logic signed [34:0]   p2_sum_r;
  logic signed [RW-1:0] p2_comp_r;
  logic [31:0]          p2_mag [3];
  logic signed [RW-1:0] p2_comp_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p2_mag[k] = p1_d_r[k][RW-1] ? 32'(-p1_d_r[k]) : 32'(p1_d_r[k]);
    end
    case (p1_op_r)
      OP_DX:   p2_comp_nxt = p1_d_r[0];
      OP_DY:   p2_comp_nxt = p1_d_r[1];
      OP_DZ:   p2_comp_nxt = p1_d_r[2];
      default: p2_comp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_op_r   <= p1_op_r;
    p2_c2_r   <= shape_r * shape_r;
    p2_sum_r  <= 35'(p1_d_r[0]) + 35'(p1_d_r[1]) + 35'(p1_d_r[2]);
    p2_comp_r <= p2_comp_nxt;
    for (int k = 0; k < 3; k++) begin
      p2_sq_r[k] <= p2_mag[k] * p2_mag[k];
      p2_np_r[k] <= 65'(p1_n_r[k]) * 65'(p1_d_r[k]);
    end
  end

  // Stage 3: sums.
  logic               p3_v_r;
  logic [2:0]         p3_op_r;
  logic [QW-1:0]      p3_rs_r;
  logic [63:0]        p3_c2_r;
  logic signed [66:0] p3_num_r;
  logic signed [66:0] p3_nsum;
  logic signed [66:0] p3_num_nxt;

  always_comb begin
    p3_nsum = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < dim_r) begin
        p3_nsum = p3_nsum + 67'(p2_np_r[k]);
      end
    end
    case (p2_op_r)
      OP_DIV:                p3_num_nxt = 67'(p2_sum_r);
      OP_DX, OP_DY, OP_DZ:   p3_num_nxt = 67'(p2_comp_r);
      OP_NEUMANN:            p3_num_nxt = p3_nsum;
      default:               p3_num_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p3_op_r  <= p2_op_r;
    p3_rs_r  <= QW'(p2_sq_r[0]) + QW'(p2_sq_r[1]) + QW'(p2_sq_r[2]);
    p3_c2_r  <= p2_c2_r;
    p3_num_r <= p3_num_nxt;
  end

  // Stage 4: denominator, numerator magnitude and status.
  ctx_t p4_ctx_nxt;

  always_comb begin
    p4_ctx_nxt       = '0;
    p4_ctx_nxt.op    = p3_op_r;
    p4_ctx_nxt.q     = p3_rs_r + QW'(p3_c2_r);
    if (p3_op_r == OP_UNDEF) begin
      p4_ctx_nxt.status = ST_BAD_OP;
    end else if (p3_op_r != OP_VALUE && p3_rs_r == '0 && p3_c2_r == '0) begin
      p4_ctx_nxt.status = ST_ZERO_DEN;
    end else begin
      p4_ctx_nxt.status = ST_OK;
    end
    if (p3_op_r == OP_LAPLACE) begin
      case (dim_r)
        2'd0: begin
          p4_ctx_nxt.numer = NW'(p3_rs_r);
          p4_ctx_nxt.neg   = (p3_rs_r != '0);
        end
        2'd1:    p4_ctx_nxt.numer = NW'(p3_c2_r);
        2'd2:    p4_ctx_nxt.numer = NW'(p3_rs_r) + (NW'(p3_c2_r) << 1);
        default: p4_ctx_nxt.numer = (NW'(p3_rs_r) << 1) + NW'(p3_c2_r) + (NW'(p3_c2_r) << 1);
      endcase
    end else begin
      p4_ctx_nxt.neg   = p3_num_r[66];
      p4_ctx_nxt.numer = p3_num_r[66] ? NW'(-p3_num_r) : NW'(p3_num_r);
    end
  end

  // Square root of q scaled by 2^(2F), one root bit per stage.
  logic            sq_v_r    [SW+1];
  ctx_t            sq_ctx_r  [SW+1];
  logic [SW+1:0]   sq_rem_r  [SW+1];
  logic [SW-1:0]   sq_root_r [SW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_ctx_r[0]  <= p4_ctx_nxt;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    logic [2*SW-1:0] x;
    logic [SW+1:0]   cand;
    logic [SW+1:0]   trial;
    logic            ge;

    always_comb begin
      x     = {sq_ctx_r[i].q, {(2 * FRAC_BITS){1'b0}}};
      cand  = {sq_rem_r[i][SW-1:0], x[2*SW-1-2*i -: 2]};
      trial = {sq_root_r[i], 2'b01};
      ge    = (cand >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      sq_ctx_r[i+1]  <= sq_ctx_r[i];
      sq_rem_r[i+1]  <= ge ? cand - trial : cand;
      sq_root_r[i+1] <= {sq_root_r[i][SW-2:0], ge};
    end
  end

  // Laplacian quotient t = numer * 2^(2F) / q, one bit per stage.
  logic            d1_v_r   [D1Q+1];
  ctx_t            d1_ctx_r [D1Q+1];
  logic [D1RW-1:0] d1_rem_r [D1Q+1];
  logic [D1Q-1:0]  d1_quo_r [D1Q+1];
  ctx_t            d1_ctx_nxt;

  always_comb begin
    d1_ctx_nxt    = sq_ctx_r[SW];
    d1_ctx_nxt.s2 = sq_root_r[SW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r[0] <= 1'b0;
    end else begin
      d1_v_r[0] <= sq_v_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    d1_ctx_r[0] <= d1_ctx_nxt;
    d1_rem_r[0] <= {1'b0, sq_ctx_r[SW].numer[NW-1:2]};
    d1_quo_r[0] <= '0;
  end

  for (genvar j = 0; j < D1Q; j++) begin : g_div1
    logic [D1Q-1:0]  low;
    logic [D1RW-1:0] cand;
    logic [D1RW-1:0] dvs;
    logic            ge;

    always_comb begin
      low  = {d1_ctx_r[j].numer[1:0], {(2 * FRAC_BITS){1'b0}}};
      cand = {d1_rem_r[j][D1RW-2:0], low[D1Q-1-j]};
      dvs  = {1'b0, d1_ctx_r[j].q};
      ge   = (cand >= dvs);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[j+1] <= 1'b0;
      end else begin
        d1_v_r[j+1] <= d1_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      d1_ctx_r[j+1] <= d1_ctx_r[j];
      d1_rem_r[j+1] <= ge ? cand - dvs : cand;
      d1_quo_r[j+1] <= {d1_quo_r[j][D1Q-2:0], ge};
    end
  end

  // Final quotient over s2, 48 bits, with overflow flagged up front.
  logic              d2_v_r   [OUT_W+1];
  ctx_t              d2_ctx_r [OUT_W+1];
  logic [D2RW-1:0]   d2_rem_r [OUT_W+1];
  logic [OUT_W-1:0]  d2_lo_r  [OUT_W+1];
  logic [OUT_W-1:0]  d2_quo_r [OUT_W+1];
  logic [D2DW-1:0]   d2_dvd;
  logic [D2RW-1:0]   d2_hi;
  ctx_t              d2_ctx_nxt;

  always_comb begin
    d2_ctx_nxt = d1_ctx_r[D1Q];
    case (d1_ctx_r[D1Q].op)
      OP_LAPLACE:          d2_dvd = D2DW'(d1_quo_r[D1Q]) << FRAC_BITS;
      OP_DIV, OP_DX, OP_DY, OP_DZ:
                           d2_dvd = D2DW'(d1_ctx_r[D1Q].numer) << (2 * FRAC_BITS);
      OP_NEUMANN:          d2_dvd = D2DW'(d1_ctx_r[D1Q].numer) << FRAC_BITS;
      default:             d2_dvd = '0;
    endcase
    d2_hi          = D2RW'(d2_dvd[D2DW-1:OUT_W]);
    d2_ctx_nxt.ovf = (d2_hi >= {1'b0, d1_ctx_r[D1Q].s2});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r[0] <= 1'b0;
    end else begin
      d2_v_r[0] <= d1_v_r[D1Q];
    end
  end

  always_ff @(posedge clk) begin
    d2_ctx_r[0] <= d2_ctx_nxt;
    d2_rem_r[0] <= d2_hi;
    d2_lo_r[0]  <= d2_dvd[OUT_W-1:0];
    d2_quo_r[0] <= '0;
  end

  for (genvar k = 0; k < OUT_W; k++) begin : g_div2
    logic [D2RW-1:0] cand;
    logic [D2RW-1:0] dvs;
    logic            ge;

    always_comb begin
      cand = {d2_rem_r[k][D2RW-2:0], d2_lo_r[k][OUT_W-1-k]};
      dvs  = {1'b0, d2_ctx_r[k].s2};
      ge   = (cand >= dvs);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[k+1] <= 1'b0;
      end else begin
        d2_v_r[k+1] <= d2_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      d2_ctx_r[k+1] <= d2_ctx_r[k];
      d2_rem_r[k+1] <= ge ? cand - dvs : cand;
      d2_lo_r[k+1]  <= d2_lo_r[k];
      d2_quo_r[k+1] <= {d2_quo_r[k][OUT_W-2:0], ge};
    end
  end

  // Output register: saturation, sign and error handling.
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;
  logic [OUT_W-1:0] lim;
  logic [OUT_W-1:0] mag;
  ctx_t             fin;

  always_comb begin
    fin = d2_ctx_r[OUT_W];
    lim = fin.neg ? OUT_NEG_LIM : OUT_POS_LIM;
    mag = (fin.ovf || d2_quo_r[OUT_W] > lim) ? lim : d2_quo_r[OUT_W];
    out_item_nxt.status = fin.status;
    if (fin.status != ST_OK) begin
      out_item_nxt.kernel_value = '0;
    end else if (fin.op == OP_VALUE) begin
      out_item_nxt.kernel_value = OUT_W'(fin.s2[SW-1:FRAC_BITS]);
    end else begin
      out_item_nxt.kernel_value = fin.neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_v_r[OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `MQK_ASSERT_AFTER(a_item_delivered, start && !busy, LAT, out_valid, "accepted item was not delivered")
  `MQK_ASSERT_SAME(a_no_phantom, out_valid, $past(start && !busy, LAT), "result without an item")
  `MQK_ASSERT_SAME(a_error_zero, out_valid && out_item.status != ST_OK, out_item.kernel_value == '0, "error result is not zero")

endmodule
